// File: design/wtosc_pkg.sv
// Shared types and constants for the wavetable oscillator.
package wtosc_pkg;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned ADDR_IN_W  = 10;
  localparam int unsigned FREQ_W     = 24;
  localparam int unsigned LOR_W      = 32;
  localparam int unsigned TLEN_W     = 11;
  localparam int unsigned SPHASE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PHASE_W    = 32;
  localparam int unsigned CNT_W      = $clog2(PHASE_W);
  localparam int unsigned STEP_W     = 34;

  localparam logic [TLEN_W-1:0]   TLEN_RST   = 11'd1024;
  localparam logic [LOR_W-1:0]    LOR_RST    = 32'd357913;
  localparam logic [SPHASE_W-1:0] SPHASE_RST = 16'd0;
  localparam logic                INTERP_RST = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TABLE_LENGTH     = 2'd0,
    CFG_LENGTH_OVER_RATE = 2'd1,
    CFG_START_PHASE      = 2'd2,
    CFG_INTERPOLATE      = 2'd3
  } cfg_idx_e;

endpackage

// File: design/wtosc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wtosc_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/wavetable_oscillator_core.sv
// Wavetable oscillator top level: pipeline, phase accumulator and wave table RAMs.
//
// Usage:
// - Request channel (in_valid_i / in_stall_o): opcode LOAD writes table_value_i
//   at table_address_i, RESTART sets the phase from start_phase and table_length,
//   TICK produces one sample and advances the phase by frequency_i scaled by
//   length_over_rate. LOAD and RESTART produce no result.
// - Result channel (out_valid_o / out_stall_i): one sample per TICK, in order.
// - Config channel (cfg_valid_i / cfg_ready_o): register index and data; write only
//   while no request is in flight.
// - Path: a TICK passes the step product, clamp, table read, multiply and output stages.
// - Throughput: one request per cycle unless in_stall_o holds it off; the phase add and
//   wrap is combinational and the two table copies give both interpolation taps in one read.
// - A table_length write starts a bit-serial remainder pass over the phase bits that folds
//   the phase into the new span; requests and config writes are held off meanwhile.
// - Reset: phase 0, config at defaults, pipeline empty. Table contents
//   are undefined until loaded.
// - Receiver stall: the output register holds; upstream stages keep filling
//   bubbles, then in_stall_o rises once every stage is occupied.
module wavetable_oscillator_core #(
  parameter int unsigned TABLE_SIZE      = 1024,
  parameter int unsigned SAMPLE_BITS     = 16,
  parameter int unsigned PHASE_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wtosc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [wtosc_pkg::OP_W-1:0]           opcode_i,
  input  logic [wtosc_pkg::ADDR_IN_W-1:0]      table_address_i,
  input  logic signed [SAMPLE_BITS-1:0]        table_value_i,
  input  logic signed [wtosc_pkg::FREQ_W-1:0]  frequency_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]        sample_o
);

  import wtosc_pkg::*;

  localparam int unsigned AW         = $clog2(TABLE_SIZE);
  localparam int unsigned INT_W      = PHASE_W - PHASE_FRAC_BITS;
  localparam int unsigned LEN_CAP    = (TABLE_SIZE < (1 << INT_W)) ? TABLE_SIZE : (1 << INT_W);
  localparam int unsigned LEN_W      = $clog2(LEN_CAP + 1);
  localparam int unsigned SPAN_W     = PHASE_W + 1;
  localparam int unsigned PROD_W     = FREQ_W + LOR_W + 1;
  localparam int unsigned PH_W       = STEP_W + 1;
  localparam int unsigned RS_W       = SPHASE_W + LEN_W + PHASE_FRAC_BITS;
  localparam int unsigned DIFF_W     = SAMPLE_BITS + 1;
  localparam int unsigned IPROD_W    = DIFF_W + PHASE_FRAC_BITS + 1;

  // ---------------------------------------------------------------- config
  logic [TLEN_W-1:0]   table_length_q;
  logic [LOR_W-1:0]    length_over_rate_q;
  logic [SPHASE_W-1:0] start_phase_q;
  logic                interpolate_q;
  logic                busy_q;
  logic                cfg_wr;

  assign cfg_ready_o = !busy_q;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q     <= TLEN_RST;
      length_over_rate_q <= LOR_RST;
      start_phase_q      <= SPHASE_RST;
      interpolate_q      <= INTERP_RST;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_TABLE_LENGTH:     table_length_q     <= cfg_data_i[TLEN_W-1:0];
        CFG_LENGTH_OVER_RATE: length_over_rate_q <= cfg_data_i[LOR_W-1:0];
        CFG_START_PHASE:      start_phase_q      <= cfg_data_i[SPHASE_W-1:0];
        CFG_INTERPOLATE:      interpolate_q      <= cfg_data_i[0];
        default:              ;
      endcase
    end
  end

  // Effective length, clamped to [2, LEN_CAP]; span is one full cycle of phase.
  logic [LEN_W-1:0]  len;
  logic [SPAN_W-1:0] span;
  logic [SPAN_W-1:0] lim;

  always_comb begin
    if (table_length_q < TLEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (32'(table_length_q) > LEN_CAP) begin
      len = LEN_W'(LEN_CAP);
    end else begin
      len = LEN_W'(table_length_q);
    end
  end

  assign span = SPAN_W'(len) << PHASE_FRAC_BITS;
  assign lim  = span - SPAN_W'(1);

  // ---------------------------------------------------------------- handshake
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic go1, go2, go3, go4, go5;
  logic in_acc, xfer;
  logic [OP_W-1:0] s2_op_q;

  assign go5 = !out_valid_q || !out_stall_i;
  assign go4 = !s4_valid_q || go5;
  assign go3 = !s3_valid_q || go4;
  assign go2 = !s2_valid_q || go3;
  assign go1 = !s1_valid_q || go2;

  assign in_stall_o = busy_q || !go1;
  assign in_acc     = in_valid_i && !in_stall_o;
  // request leaves stage 2: table access and phase update happen here
  assign xfer       = s2_valid_q && go3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (go1) begin
        s1_valid_q <= in_acc;
      end
      if (go2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (go3) begin
        s3_valid_q <= s2_valid_q && (s2_op_q == OP_TICK);
      end
      if (go4) begin
        s4_valid_q <= s3_valid_q;
      end
      if (go5) begin
        out_valid_q <= s4_valid_q;
      end
    end
  end

  // ---------------------------------------------------------------- stage 1: step product
  logic [OP_W-1:0]               s1_op_q;
  logic [ADDR_IN_W-1:0]          s1_addr_q;
  logic signed [SAMPLE_BITS-1:0] s1_value_q;
  logic signed [PROD_W-1:0]      s1_prod_q;
  logic signed [PROD_W-1:0]      s1_prod_d;

  assign s1_prod_d = frequency_i * $signed({1'b0, length_over_rate_q});

  always_ff @(posedge clk_i) begin
    if (go1) begin
      s1_op_q    <= opcode_i;
      s1_addr_q  <= table_address_i;
      s1_value_q <= table_value_i;
      s1_prod_q  <= s1_prod_d;
    end
  end

  // ---------------------------------------------------------------- stage 2: floor shift, clamp
  logic [ADDR_IN_W-1:0]          s2_addr_q;
  logic signed [SAMPLE_BITS-1:0] s2_value_q;
  logic signed [STEP_W-1:0]      s2_step_q;
  logic signed [STEP_W-1:0]      s2_step_d;
  logic signed [PROD_W-1:0]      step_shr;
  logic signed [PROD_W-1:0]      lim_w;

  assign step_shr = s1_prod_q >>> (PHASE_W - PHASE_FRAC_BITS);
  assign lim_w    = $signed(PROD_W'(lim));

  always_comb begin
    if (step_shr > lim_w) begin
      s2_step_d = STEP_W'(lim_w);
    end else if (step_shr < -lim_w) begin
      s2_step_d = STEP_W'(-lim_w);
    end else begin
      s2_step_d = STEP_W'(step_shr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go2) begin
      s2_op_q    <= s1_op_q;
      s2_addr_q  <= s1_addr_q;
      s2_value_q <= s1_value_q;
      s2_step_q  <= s2_step_d;
    end
  end

  // ---------------------------------------------------------------- phase accumulator
  logic [PHASE_W-1:0] phase_q;   // phase in use, inside the span except during a remainder pass
  logic [PHASE_W-1:0] raw_q;     // phase as last set by a tick or restart
  logic [PHASE_W-1:0] rem_q;
  logic [CNT_W-1:0]   cnt_q;

  logic signed [PH_W-1:0] ph_sum;
  logic signed [PH_W-1:0] ph_wrap;
  logic signed [PH_W-1:0] span_s;
  logic [PHASE_W-1:0]     phase_tick;
  logic [RS_W-1:0]        rs_prod;
  logic [PHASE_W-1:0]     phase_restart;
  logic [SPAN_W-1:0]      rem_t;
  logic [PHASE_W-1:0]     rem_next;

  assign span_s = $signed(PH_W'(span));
  assign ph_sum = $signed(PH_W'(phase_q)) + PH_W'(s2_step_q);

  always_comb begin
    if (ph_sum >= span_s) begin
      ph_wrap = ph_sum - span_s;
    end else if (ph_sum < 0) begin
      ph_wrap = ph_sum + span_s;
    end else begin
      ph_wrap = ph_sum;
    end
  end

  assign phase_tick = ph_wrap[PHASE_W-1:0];

  // start_phase is Q0.16; move to PHASE_FRAC_BITS fraction bits by truncation
  assign rs_prod       = (RS_W'(start_phase_q) * RS_W'(len)) << PHASE_FRAC_BITS;
  assign phase_restart = PHASE_W'(rs_prod >> SPHASE_W);

  // restoring remainder, one phase bit per cycle, MSB first
  assign rem_t    = {rem_q, raw_q[cnt_q]};
  assign rem_next = (rem_t >= span) ? PHASE_W'(rem_t - span) : PHASE_W'(rem_t);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      raw_q   <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (xfer && (s2_op_q == OP_TICK)) begin
        phase_q <= phase_tick;
        raw_q   <= phase_tick;
      end else if (xfer && (s2_op_q == OP_RESTART)) begin
        phase_q <= phase_restart;
        raw_q   <= phase_restart;
      end
      if (busy_q) begin
        rem_q <= rem_next;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q  <= 1'b0;
          phase_q <= rem_next;
        end
      end else if (cfg_wr && (cfg_index_i == CFG_TABLE_LENGTH)) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PHASE_W - 1);
        rem_q  <= '0;
      end
    end
  end

  // ---------------------------------------------------------------- wave table
  // Two copies written together so both interpolation taps are read in the same cycle.
  logic [INT_W-1:0]           base_idx;
  logic [INT_W:0]             next_inc;
  logic [INT_W:0]             next_idx;
  logic [PHASE_FRAC_BITS-1:0] frac;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_BITS-1:0]     ram_a_rdata;
  logic [SAMPLE_BITS-1:0]     ram_b_rdata;

  assign base_idx  = phase_q[PHASE_W-1:PHASE_FRAC_BITS];
  assign frac      = phase_q[PHASE_FRAC_BITS-1:0];
  assign next_inc  = (INT_W + 1)'(base_idx) + (INT_W + 1)'(1);
  assign next_idx  = (32'(next_inc) >= 32'(len)) ? '0 : next_inc;

  assign ram_we    = xfer && (s2_op_q == OP_LOAD) && (32'(s2_addr_q) < TABLE_SIZE);
  assign ram_waddr = AW'(s2_addr_q);

  wtosc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s2_value_q),
    .re_i    (go3),
    .raddr_i (AW'(base_idx)),
    .rdata_o (ram_a_rdata)
  );

  wtosc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (TABLE_SIZE)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s2_value_q),
    .re_i    (go3),
    .raddr_i (AW'(next_idx)),
    .rdata_o (ram_b_rdata)
  );

  // ---------------------------------------------------------------- stage 3: taps in RAM output
  logic [PHASE_FRAC_BITS-1:0] s3_frac_q;

  always_ff @(posedge clk_i) begin
    if (go3) begin
      // truncating lookup is interpolation with a zero fraction
      s3_frac_q <= interpolate_q ? frac : '0;
    end
  end

  // ---------------------------------------------------------------- stage 4: (b - a) * frac
  logic signed [SAMPLE_BITS-1:0] tap_a;
  logic signed [SAMPLE_BITS-1:0] tap_b;
  logic signed [DIFF_W-1:0]      tap_diff;
  logic signed [IPROD_W-1:0]     s4_prod_q;
  logic signed [SAMPLE_BITS-1:0] s4_base_q;

  assign tap_a    = $signed(ram_a_rdata);
  assign tap_b    = $signed(ram_b_rdata);
  assign tap_diff = DIFF_W'(tap_b) - DIFF_W'(tap_a);

  always_ff @(posedge clk_i) begin
    if (go4) begin
      s4_prod_q <= tap_diff * $signed({1'b0, s3_frac_q});
      s4_base_q <= tap_a;
    end
  end

  // ---------------------------------------------------------------- stage 5: output register
  logic signed [IPROD_W-1:0]     interp_sum;
  logic signed [SAMPLE_BITS-1:0] out_sample_q;

  // result lies between the taps, so truncation never overflows
  assign interp_sum = IPROD_W'(s4_base_q) + (s4_prod_q >>> PHASE_FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (go5) begin
      out_sample_q <= SAMPLE_BITS'(interp_sum);
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;

`ifndef NO_ASSERTIONS
  // no request taken while the remainder pass runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("request accepted during phase remainder pass");

  // remainder pass ends once the last phase bit is folded in
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> ##32 !busy_q)
    else $error("phase remainder pass length wrong");

  // phase in use stays inside the span outside the pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ({1'b0, phase_q} < span))
    else $error("phase outside span");

  // phase only moves on tick, restart or pass completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !(xfer && (s2_op_q == OP_TICK || s2_op_q == OP_RESTART)))
      |=> $stable(phase_q))
    else $error("phase changed without cause");
`endif

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for wavetable_oscillator_core: table loads, ticks, restarts, config.
`timescale 1ns / 1ps

module tb_top;
  import wtosc_pkg::*;

  localparam int unsigned TBL_DEPTH    = 1024;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned IDLE_PCT     = 37;
  // Loads and restarts give no sample; this covers the pipeline after the last sample.
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned BURSTS       = 8;
  // requests of the whole run, tap loads included
  localparam int unsigned ITEMS_TOTAL  = 1050;

  // opcode 3 has no function; the block must drop it
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;

  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [OP_W-1:0]         opcode_i;
  logic [ADDR_IN_W-1:0]    table_address_i;
  logic signed [15:0]      table_value_i;
  logic signed [FREQ_W-1:0] frequency_i;

  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [15:0]      sample_o;

  // Oscillator shadow: config, phase and table as the block should hold them.
  logic [TLEN_W-1:0]       cfg_tlen   = TLEN_RST;
  logic [LOR_W-1:0]        cfg_lor    = LOR_RST;
  logic [SPHASE_W-1:0]     cfg_sphase = SPHASE_RST;
  logic                    cfg_interp = INTERP_RST;
  logic [PHASE_W-1:0]      osc_phase  = '0;
  logic signed [15:0]      wave_mem [TBL_DEPTH];
  bit                      wave_loaded [TBL_DEPTH];

  logic signed [15:0]      sample_q [$];   // samples still owed by the block
  int unsigned             n_fail    = 0;
  int unsigned             n_sent    = 0;
  int unsigned             cycle_cnt = 0;
  bit                      calm      = 1'b0;  // no idling on either side while set

  wavetable_oscillator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .table_address_i (table_address_i),
    .table_value_i   (table_value_i),
    .frequency_i     (frequency_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .sample_o        (sample_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Span in use: the length register clamped to 2..TBL_DEPTH.
  function automatic int unsigned eff_len();
    if (cfg_tlen < 2) return 2;
    if (cfg_tlen > TBL_DEPTH) return TBL_DEPTH;
    return cfg_tlen;
  endfunction

  // Table taps at the current phase. A phase left past the span by a shrink
  // of the table length is folded back first.
  function automatic void read_taps(output int base, output int nxt,
                                    output longint frac, output longint ph);
    longint span;
    span = longint'(eff_len()) << FRAC_BITS;
    ph   = longint'(osc_phase);
    if (ph >= span) ph = ph % span;
    base = int'(ph >> FRAC_BITS);
    frac = ph & ((64'd1 << FRAC_BITS) - 1);
    nxt  = base + 1;
    // next index wraps to 0 at the span end in place of a guard point
    if (nxt >= int'(eff_len())) nxt = 0;
  endfunction

  // Sample for one tick, then phase advance with clamped step and single wrap.
  function automatic logic signed [15:0] tick_sample(input logic signed [FREQ_W-1:0] freq);
    int     base, nxt;
    longint frac, ph, span, a, b, val, prod, step, lim;
    read_taps(base, nxt, frac, ph);
    span = longint'(eff_len()) << FRAC_BITS;
    a    = longint'(wave_mem[base]);
    b    = longint'(wave_mem[nxt]);
    // arithmetic shift floors, so the result stays between a and b
    val  = cfg_interp ? a + (((b - a) * frac) >>> FRAC_BITS) : a;
    prod = longint'(freq) * longint'(cfg_lor);   // Q15.8 x Q8.24 = Q.32
    step = prod >>> (32 - FRAC_BITS);
    lim  = span - 1;
    if (step > lim) step = lim;
    if (step < -lim) step = -lim;
    ph = ph + step;
    if (ph >= span) ph = ph - span;
    else if (ph < 0) ph = ph + span;
    osc_phase = ph[PHASE_W-1:0];
    return 16'(val);
  endfunction

  // Update the shadow for one accepted request.
  function automatic void apply_request(input logic [OP_W-1:0] op,
                                        input logic [ADDR_IN_W-1:0] addr,
                                        input logic signed [15:0] value,
                                        input logic signed [FREQ_W-1:0] freq);
    case (op)
      OP_LOAD: begin
        wave_mem[addr]    = value;
        wave_loaded[addr] = 1'b1;
      end
      OP_TICK:    sample_q.push_back(tick_sample(freq));
      OP_RESTART: osc_phase = PHASE_W'(32'(cfg_sphase) * eff_len());
      default: ;
    endcase
  endfunction

  // One request on the input channel. Entered and left at a falling edge;
  // valid stays high on exit so back-to-back requests need no bubble.
  task automatic send_request(input logic [OP_W-1:0] op,
                              input logic [ADDR_IN_W-1:0] addr,
                              input logic signed [15:0] value,
                              input logic signed [FREQ_W-1:0] freq);
    while (idle_now()) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    opcode_i        = op;
    table_address_i = addr;
    table_value_i   = value;
    frequency_i     = freq;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_request(op, addr, value, freq);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Tick with noise on the unused fields. Taps not yet loaded get a random
  // word first, so no tick ever reads an undefined entry.
  task automatic send_tick(input logic signed [FREQ_W-1:0] freq);
    int     base, nxt;
    longint frac, ph;
    read_taps(base, nxt, frac, ph);
    if (!wave_loaded[base])
      send_request(OP_LOAD, ADDR_IN_W'(base), 16'($urandom), FREQ_W'($urandom));
    if (!wave_loaded[nxt])
      send_request(OP_LOAD, ADDR_IN_W'(nxt), 16'($urandom), FREQ_W'($urandom));
    send_request(OP_TICK, ADDR_IN_W'($urandom), 16'($urandom), freq);
  endtask

  task automatic send_noop(input logic [OP_W-1:0] op);
    send_request(op, ADDR_IN_W'($urandom), 16'($urandom), FREQ_W'($urandom));
  endtask

  // Register write with the block idle: owed samples in, pipeline drained.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    in_valid_i = 1'b0;
    while (sample_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TABLE_LENGTH:     cfg_tlen   = data[TLEN_W-1:0];
      CFG_LENGTH_OVER_RATE: cfg_lor    = data[LOR_W-1:0];
      CFG_START_PHASE:      cfg_sphase = data[SPHASE_W-1:0];
      CFG_INTERPOLATE:      cfg_interp = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Each accepted sample against the oldest one owed.
  always @(posedge clk_i) begin
    logic signed [15:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sample_q.size() == 0) begin
        $error("sample: expected none, actual %0d", sample_o);
        n_fail++;
      end else begin
        want = sample_q.pop_front();
        if (sample_o !== want) begin
          $error("sample: expected %0d, actual %0d", want, sample_o);
          n_fail++;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(negedge clk_i) out_stall_i = idle_now();

  // Extreme table words, start of span, full-scale frequency both ways, a wrap below
  // zero onto the last entry and back through index 0.
  task automatic test_lookup_extremes();
    send_request(OP_LOAD, 10'd0, 16'sh7FFF, FREQ_W'($urandom));
    send_request(OP_LOAD, 10'd1, 16'sh8000, FREQ_W'($urandom));
    send_request(OP_LOAD, 10'd1023, 16'sh8000, FREQ_W'($urandom));
    send_tick(24'sd0);
    send_tick(24'sh7FFFFF);   // full-scale positive step, below the clamp
    send_tick(24'sh800000);   // full-scale negative step, wraps below zero to the last entry
    send_tick(24'sd1);
    send_tick(24'sd112640);   // 440 Hz
  endtask

  // Every register at its extremes; length 0 and 1 clamp to 2, 2047 to full size.
  task automatic test_config_extremes();
    write_reg(CFG_INTERPOLATE, 32'd0);
    send_tick(24'sd112640);
    send_tick(-24'sd112640);
    write_reg(CFG_INTERPOLATE, 32'd1);
    write_reg(CFG_LENGTH_OVER_RATE, 32'd0);
    send_tick(24'sh7FFFFF);   // zero step
    write_reg(CFG_LENGTH_OVER_RATE, 32'hFFFF_FFFF);
    send_tick(24'sd1);
    send_tick(24'sh800000);
    write_reg(CFG_LENGTH_OVER_RATE, LOR_RST);
    write_reg(CFG_TABLE_LENGTH, 32'd0);
    write_reg(CFG_START_PHASE, 32'h0000_FFFF);
    send_noop(OP_RESTART);    // top of a two-entry span, next tap wraps
    send_tick(24'sd256);
    write_reg(CFG_TABLE_LENGTH, 32'd1);
    send_tick(24'sd0);
    write_reg(CFG_TABLE_LENGTH, 32'd2047);
    send_tick(24'sd25600);
  endtask

  // Shrinking the table under a phase near the top of the old span.
  task automatic test_phase_fold();
    write_reg(CFG_TABLE_LENGTH, 32'd1024);
    write_reg(CFG_START_PHASE, 32'h0000_FFFF);
    send_noop(OP_RESTART);
    write_reg(CFG_TABLE_LENGTH, 32'd3);
    send_tick(24'sd0);
    send_tick(24'sd25600);
  endtask

  task automatic test_unused_opcode();
    send_noop(OP_UNUSED);
    send_noop(OP_UNUSED);
    send_tick(24'sd4096);
  endtask

  // Fresh register values between bursts; each register is skipped at times.
  task automatic shuffle_regs();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(5))
      0: d[TLEN_W-1:0] = 11'd0;
      1: d[TLEN_W-1:0] = 11'd2047;
      2: d[TLEN_W-1:0] = 11'd2;
      3: d[TLEN_W-1:0] = 11'd1024;
      default: d[TLEN_W-1:0] = 11'($urandom_range(2, $urandom_range(1) ? 64 : 1024));
    endcase
    if ($urandom_range(3) != 0) write_reg(CFG_TABLE_LENGTH, d);
    case ($urandom_range(5))
      0: d = 32'd0;
      1: d = 32'hFFFF_FFFF;
      2: d = $urandom;
      default: d = $urandom_range(0, 32'd4194304);   // audio-rate steps
    endcase
    if ($urandom_range(3) != 0) write_reg(CFG_LENGTH_OVER_RATE, d);
    if ($urandom_range(1)) write_reg(CFG_START_PHASE, $urandom);
    if ($urandom_range(1)) write_reg(CFG_INTERPOLATE, $urandom);
  endtask

  function automatic logic signed [FREQ_W-1:0] pick_freq();
    case ($urandom_range(9))
      0: return $urandom_range(1) ? 24'sh7FFFFF : 24'sh800000;
      1, 2, 3: return FREQ_W'($urandom);
      4, 5: return FREQ_W'(int'($urandom_range(0, 4000)) - 2000);
      default: return FREQ_W'(int'($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // Mostly ticks, with loads, restarts and dropped opcodes mixed in.
  task automatic test_random_traffic();
    int unsigned pick;
    for (int unsigned burst = 0; burst < BURSTS; burst++) begin
      shuffle_regs();
      calm = (burst == 3);
      while (n_sent < (ITEMS_TOTAL * (burst + 1)) / BURSTS) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_tick(pick_freq());
        end else if (pick < 85) begin
          send_request(OP_LOAD, ADDR_IN_W'($urandom), 16'($urandom), FREQ_W'($urandom));
        end else if (pick < 93) begin
          send_noop(OP_RESTART);
        end else begin
          send_noop(OP_UNUSED);
        end
      end
    end
    calm = 1'b0;
  endtask

  task automatic finish_run();
    in_valid_i = 1'b0;
    while (sample_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES * 4) @(negedge clk_i);
    if (n_fail == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_TABLE_LENGTH;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    opcode_i        = OP_LOAD;
    table_address_i = '0;
    table_value_i   = '0;
    frequency_i     = '0;
    foreach (wave_mem[i]) begin
      wave_mem[i]    = '0;
      wave_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_lookup_extremes();
    test_config_extremes();
    test_phase_fold();
    test_unused_opcode();
    test_random_traffic();
    finish_run();
  end

endmodule

// File: sim.f
design/wtosc_pkg.sv
design/wtosc_ram.sv
design/wavetable_oscillator_core.sv
tb/tb_top.sv
